>>> hw/rtl/shb_pkg.sv
`timescale 1ns / 1ps

package shb_pkg;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_EMIT
  } state_t;

  // Source of the byte shifted into the block register
  typedef enum logic [1:0] {
    BS_MSG,
    BS_MARK,
    BS_ZERO,
    BS_LEN
  } byte_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       shift_en;
    byte_sel_t  byte_sel;
    logic       count_en;
    logic       load_vars;
    logic       round_en;
    logic [5:0] round_idx;
    logic       hash_add;
    logic       hash_init;
    logic       clear_count;
    logic [2:0] word_idx;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [5:0] fill;
  } dp_stat_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [5:0] LAST_BYTE_POS = 6'd63;
  localparam logic [5:0] LEN_START_POS = 6'd56;

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] r;
    unique case (idx)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/shb_in_if.sv
`timescale 1ns / 1ps

interface shb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source(output valid, output data_byte, output byte_present,
                 output end_of_message, input ready);
  modport sink(input valid, input data_byte, input byte_present,
               input end_of_message, output ready);
endinterface

>>> hw/rtl/shb_out_if.sv
`timescale 1ns / 1ps

interface shb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source(output valid, output digest_word, output word_index,
                 output last_word, input ready);
  modport sink(input valid, input digest_word, input word_index,
               input last_word, output ready);
endinterface

>>> hw/rtl/shb_ctrl.sv
`timescale 1ns / 1ps

module shb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_present,
  input  logic              in_end,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_last,
  input  shb_pkg::dp_stat_t stat,
  output shb_pkg::dp_cmd_t  cmd
);

  shb_pkg::state_t state;
  shb_pkg::state_t state_next;
  logic [5:0] round;
  logic [2:0] word_idx;
  logic       pend_end;   // message ended on a full block, padding still due
  logic       mark_done;  // 0x80 marker already shifted in
  logic       len_ok;     // current padding block carries the length

  logic in_fire;
  logic out_fire;
  logic fill_last;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign fill_last = (stat.fill == shb_pkg::LAST_BYTE_POS);

  always_comb begin
    state_next = state;
    unique case (state)
      shb_pkg::ST_IDLE: begin
        if (in_fire) begin
          priority if (in_present && fill_last) state_next = shb_pkg::ST_ROUND;
          else if (in_end) state_next = shb_pkg::ST_PAD;
          else state_next = shb_pkg::ST_IDLE;
        end
      end
      shb_pkg::ST_ROUND: begin
        if (round == shb_pkg::LAST_ROUND) state_next = shb_pkg::ST_UPDATE;
      end
      shb_pkg::ST_UPDATE: begin
        priority if (mark_done && len_ok) state_next = shb_pkg::ST_EMIT;
        else if (mark_done || pend_end) state_next = shb_pkg::ST_PAD;
        else state_next = shb_pkg::ST_IDLE;
      end
      shb_pkg::ST_PAD: begin
        if (fill_last) state_next = shb_pkg::ST_ROUND;
      end
      shb_pkg::ST_EMIT: begin
        if (out_fire && word_idx == shb_pkg::LAST_WORD_IDX) state_next = shb_pkg::ST_IDLE;
      end
      default: state_next = shb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= shb_pkg::ST_IDLE;
      round     <= '0;
      word_idx  <= '0;
      pend_end  <= 1'b0;
      mark_done <= 1'b0;
      len_ok    <= 1'b0;
    end else begin
      state <= state_next;
      round <= (state == shb_pkg::ST_ROUND) ? round + 6'd1 : '0;
      if (state == shb_pkg::ST_IDLE && in_fire) pend_end <= in_end;
      if (state == shb_pkg::ST_PAD) begin
        pend_end <= 1'b0;
        if (!mark_done) begin
          mark_done <= 1'b1;
          len_ok    <= (stat.fill < shb_pkg::LEN_START_POS);
        end
      end
      if (state == shb_pkg::ST_UPDATE && mark_done) len_ok <= 1'b1;
      if (state == shb_pkg::ST_EMIT && out_fire) begin
        word_idx <= word_idx + 3'd1;
        if (word_idx == shb_pkg::LAST_WORD_IDX) begin
          mark_done <= 1'b0;
          len_ok    <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.byte_sel  = shb_pkg::BS_MSG;
    cmd.round_idx = round;
    cmd.word_idx  = word_idx;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    out_last      = (word_idx == shb_pkg::LAST_WORD_IDX);
    unique case (state)
      shb_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.shift_en  = in_fire && in_present;
        cmd.count_en  = in_fire && in_present;
        cmd.load_vars = in_fire && in_present && fill_last;
      end
      shb_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
      end
      shb_pkg::ST_UPDATE: begin
        cmd.hash_add = 1'b1;
      end
      shb_pkg::ST_PAD: begin
        cmd.shift_en  = 1'b1;
        cmd.load_vars = fill_last;
        priority if (!mark_done) cmd.byte_sel = shb_pkg::BS_MARK;
        else if (len_ok && stat.fill >= shb_pkg::LEN_START_POS)
          cmd.byte_sel = shb_pkg::BS_LEN;
        else cmd.byte_sel = shb_pkg::BS_ZERO;
      end
      shb_pkg::ST_EMIT: begin
        out_valid       = 1'b1;
        cmd.hash_init   = out_fire && word_idx == shb_pkg::LAST_WORD_IDX;
        cmd.clear_count = out_fire && word_idx == shb_pkg::LAST_WORD_IDX;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/shb_datapath.sv
`timescale 1ns / 1ps

module shb_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        data_byte,
  input  shb_pkg::dp_cmd_t  cmd,
  output shb_pkg::dp_stat_t stat,
  output logic [31:0]       digest_word
);

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // Block and schedule share one shift line; word 15 is the oldest.
  logic [15:0][31:0] win;
  logic [31:0] hash [8];
  logic [31:0] v    [8];
  logic [5:0]  fill;
  logic [63:0] bit_count;

  logic [7:0]  shift_byte;
  logic [31:0] w_next;
  logic [31:0] t1;
  logic [31:0] t2;

  assign stat.fill   = fill;
  assign digest_word = hash[cmd.word_idx];

  always_comb begin
    unique case (cmd.byte_sel)
      shb_pkg::BS_MSG:  shift_byte = data_byte;
      shb_pkg::BS_MARK: shift_byte = shb_pkg::PAD_MARK;
      shb_pkg::BS_LEN:  shift_byte = bit_count[{~fill[2:0], 3'b000} +: 8];
      default:          shift_byte = 8'h00;
    endcase
  end

  assign w_next = small_s1(win[1]) + win[6] + small_s0(win[14]) + win[15];
  assign t1 = v[7] + big_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + shb_pkg::round_k(cmd.round_idx) + win[15];
  assign t2 = big_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  // Advance one byte into the line, or one schedule word per round.
  always_ff @(posedge clk) begin
    if (cmd.shift_en) win <= {win[15][23:0], win[14:0], shift_byte};
    else if (cmd.round_en) win <= {win[14:0], w_next};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      for (int i = 0; i < 8; i++) v[i] <= hash[i];
    end else if (cmd.round_en) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      bit_count <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= shb_pkg::init_hash(3'(i));
    end else begin
      if (cmd.shift_en) fill <= fill + 6'd1;
      if (cmd.clear_count) bit_count <= '0;
      else if (cmd.count_en) bit_count <= bit_count + 64'd8;
      if (cmd.hash_init) begin
        for (int i = 0; i < 8; i++) hash[i] <= shb_pkg::init_hash(3'(i));
      end else if (cmd.hash_add) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
      end
    end
  end

endmodule

>>> hw/rtl/sha256_byte_stream_hasher_unit.sv
`timescale 1ns / 1ps
// A byte that does not fill a block is taken without a stall; a byte that fills one holds
// the input through the 64 rounds, one per cycle, and the hash add.
// End of message: the padding bytes, one or two compressions, then eight digest
// words, one per cycle while the sink is ready.
// Input: the one shared round unit stalls input while each block is compressed.
// Reset (rst, synchronous): hash to initial values, fill and bit count to zero, idle.
module sha256_byte_stream_hasher_unit (
  input  logic       clk,
  input  logic       rst,
  shb_in_if.sink     msg,
  shb_out_if.source  digest
);

  // Command and status between the sequencer and the round datapath.
  shb_pkg::dp_cmd_t  cmd;
  shb_pkg::dp_stat_t stat;
  logic              out_last;

  // Sequencer: takes one request at a time in idle, walks the 64 rounds,
  // pads the final block(s) and presents the eight digest words.
  shb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (msg.valid),
    .in_present (msg.byte_present),
    .in_end     (msg.end_of_message),
    .in_ready   (msg.ready),
    .out_valid  (digest.valid),
    .out_ready  (digest.ready),
    .out_last   (out_last),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: 512-bit block/schedule shift line, working variables, hash
  // state, fill position and the 64-bit message bit count.
  shb_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (msg.data_byte),
    .cmd         (cmd),
    .stat        (stat),
    .digest_word (digest.digest_word)
  );

  // Word index and last flag come straight from the sequencer's counter.
  assign digest.word_index = cmd.word_idx;
  assign digest.last_word  = out_last;

  // Input is never taken while a digest word is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg.ready && digest.valid))
    else $error("request accepted while digest pending");

  // After the final word goes out the hasher is ready for a new message.
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && digest.last_word) |=> msg.ready)
    else $error("not idle after last digest word");

  // Digest words advance one index at a time without a gap.
  a_word_advance: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && !digest.last_word) |=>
      (digest.valid && digest.word_index == $past(digest.word_index) + 3'd1))
    else $error("digest word index skipped");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned TARGET_REQUESTS = 280;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_entry_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Running SHA-256 state plus the queue of digest words still owed by the block.
  class digest_scoreboard;
    logic [31:0]   chain [8];
    logic [7:0]    block_buf [64];
    logic [5:0]    fill;
    logic [63:0]   bit_count;
    digest_entry_t digest_q [$];
    int unsigned   mismatches;

    function new();
      restart();
      mismatches = 0;
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = SHA_IV[i];
      fill = '0;
      bit_count = '0;
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, g, h;
      logic [31:0] t1, t2, w2, w15;
      for (int i = 0; i < 16; i++)
        w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      {a, b, c, d} = {chain[0], chain[1], chain[2], chain[3]};
      {e, f, g, h} = {chain[4], chain[5], chain[6], chain[7]};
      for (int r = 0; r < 64; r++) begin
        if (r >= 16) begin
          w2  = w[(r - 2) & 15];
          w15 = w[(r - 15) & 15];
          w[r & 15] = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + w[(r - 7) & 15] +
                      (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + w[r & 15];
        end
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) +
             SHA_K[r] + w[r & 15];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // Pad with the marker, zeros and the big-endian bit length; spill into a
    // second block when fewer than eight bytes remain after the marker.
    function void pad_and_close();
      int pos;
      pos = int'(fill);
      block_buf[pos] = shb_pkg::PAD_MARK;
      pos++;
      if (pos > int'(shb_pkg::LEN_START_POS)) begin
        while (pos < 64) begin
          block_buf[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < int'(shb_pkg::LEN_START_POS)) begin
        block_buf[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++)
        block_buf[int'(shb_pkg::LEN_START_POS) + i] = bit_count[63 - 8*i -: 8];
      compress();
    endfunction

    function void note_request(input logic [7:0] data_byte, input logic byte_present,
                               input logic end_of_message);
      digest_entry_t entry;
      if (byte_present) begin
        block_buf[fill] = data_byte;
        fill = fill + 6'd1;
        bit_count += 64'd8;
        if (fill == 6'd0) compress();
      end
      if (end_of_message) begin
        pad_and_close();
        for (int i = 0; i < 8; i++) begin
          entry.word  = chain[i];
          entry.index = 3'(i);
          entry.last  = (i == 7);
          digest_q = {digest_q, entry};
        end
        restart();
      end
    endfunction

    function void check_word(input logic [31:0] word, input logic [2:0] index,
                             input logic last);
      digest_entry_t want;
      if (digest_q.size() == 0) begin
        $error("digest_word %h arrived with no digest outstanding", word);
        mismatches++;
        return;
      end
      want = digest_q.pop_front();
      if (word !== want.word) begin
        $error("digest_word: expected %h, actual %h", want.word, word);
        mismatches++;
      end
      if (index !== want.index) begin
        $error("word_index: expected %0d, actual %0d", want.index, index);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_word: expected %0b, actual %0b", want.last, last);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return digest_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  shb_in_if  msg_if();
  shb_out_if digest_if();

  sha256_byte_stream_hasher_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_if.sink),
    .digest (digest_if.source)
  );

  digest_scoreboard sb;
  int unsigned      counted_requests;
  int unsigned      burst_left;
  int unsigned      idle_count;
  int unsigned      sink_phase;
  int               boundary_len [6] = '{55, 56, 57, 63, 64, 65};

  always #2 clk = ~clk;

  // Drive known values from time zero, with reset asserted.
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    msg_if.valid = 1'b0;
    msg_if.data_byte = 8'h00;
    msg_if.byte_present = 1'b0;
    msg_if.end_of_message = 1'b0;
    digest_if.ready = 1'b0;
    sink_phase = 0;
    sb = new();
  end

  // Receiver: cycle through always-ready, random stalls and a fixed repeating ready pattern.
  always @(negedge clk) begin
    sink_phase <= sink_phase + 1;
    case ((sink_phase / 300) % 3)
      0: begin
        digest_if.ready <= 1'b1;
      end
      1: begin
        digest_if.ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        digest_if.ready <= ((sink_phase % 7) < 4);
      end
    endcase
  end

  // Check every digest word taken by the receiver against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && digest_if.valid && digest_if.ready)
      sb.check_word(digest_if.digest_word, digest_if.word_index, digest_if.last_word);
  end

  // Drop valid for a gap of length n; scramble the payload so idle cycles carry noise.
  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      msg_if.valid <= 1'b0;
      msg_if.data_byte <= 8'($urandom_range(0, 255));
      msg_if.byte_present <= 1'($urandom_range(0, 1));
      msg_if.end_of_message <= 1'($urandom_range(0, 1));
    end
  endtask

  // Present one request and hold it until the block takes it. The sender runs
  // in bursts; at the end of a burst insert a gap, often zero long.
  task automatic send_request(input logic [7:0] data_byte, input logic byte_present,
                              input logic end_of_message);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 8));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    msg_if.valid <= 1'b1;
    msg_if.data_byte <= data_byte;
    msg_if.byte_present <= byte_present;
    msg_if.end_of_message <= end_of_message;
    do @(posedge clk); while (!msg_if.ready);
    sb.note_request(data_byte, byte_present, end_of_message);
    if (byte_present || end_of_message) counted_requests++;
  endtask

  // Stop sending and wait until every owed digest word has been taken.
  task automatic drain_digests();
    hold_off(1);
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // One message of len random bytes with scattered empty requests. The end
  // marker rides on the last byte or follows as a request of its own.
  task automatic send_message(input int len);
    logic joint;
    joint = 1'($urandom_range(0, 1));
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_request(8'($urandom_range(0, 255)), 1'b1, joint && (k == len - 1));
    end
    if (!(joint && len > 0)) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Watchdog: end the run once nothing has been accepted for too long.
  initial begin
    idle_count = 0;
    while (idle_count < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (msg_if.valid && msg_if.ready) || (digest_if.valid && digest_if.ready))
        idle_count = 0;
      else
        idle_count++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int len;
    int msg_idx;
    counted_requests = 0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty message with a stray byte beside the end marker.
    send_request(8'h5a, 1'b0, 1'b1);
    // Byte and end together, at both byte extremes.
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    // Empty requests that must change nothing, then "abc" with a separate end.
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b0);
    send_request(8'h3c, 1'b0, 1'b1);
    drain_digests();

    // Random messages: start with a two-block pad and an exact full block,
    // then mostly short messages with the odd one near a block boundary.
    msg_idx = 0;
    while (counted_requests < TARGET_REQUESTS) begin
      case (msg_idx)
        0: len = 56;
        1: len = 64;
        default: begin
          if ($urandom_range(0, 4) == 0)
            len = boundary_len[$urandom_range(0, 5)];
          else
            len = $urandom_range(0, 20);
        end
      endcase
      send_message(len);
      if ($urandom_range(0, 3) == 0) drain_digests();
      msg_idx++;
    end

    drain_digests();
    // Catch any spurious digest words after the last expected one.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/shb_pkg.sv
hw/rtl/shb_in_if.sv
hw/rtl/shb_out_if.sv
hw/rtl/shb_ctrl.sv
hw/rtl/shb_datapath.sv
hw/rtl/sha256_byte_stream_hasher_unit.sv
tb/tb.sv
